>>> rtl/per_ue_buffer_report_tracker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the buffer report tracker
// Shared shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef PER_UE_BUFFER_REPORT_TRACKER_DEFINES_SVH
`define PER_UE_BUFFER_REPORT_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BUFRPT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BUFRPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never hold.
`define BUFRPT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

>>> rtl/bufrpt_pkg.sv
// ----------------------------------------------------------------------------
// Buffer report tracker package
// Table sizing, register codes, payload types and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bufrpt_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_PERIOD   = 4'd0,
    CFG_BURST_THRESHOLD = 4'd1
  } cfg_reg_e;

  localparam logic [15:0] REPORT_PERIOD_RST   = 16'd50;
  localparam logic [31:0] BURST_THRESHOLD_RST = 32'd100000;

  typedef struct packed {
    logic [15:0] user_id;
    logic [63:0] event_time;
    logic [9:0]  frame_number;
    logic [7:0]  slot_number;
    logic        report_kind;
    logic [31:0] buffered_bytes;
    logic [7:0]  group_id;
  } bsr_item_t;

  typedef struct packed {
    logic [63:0] out_time;
    logic [15:0] out_user;
    logic [9:0]  out_frame;
    logic [7:0]  out_slot;
    logic        out_kind;
    logic [31:0] out_bytes;
    logic [7:0]  out_group;
    logic [31:0] event_count;
    logic [31:0] peak_seen;
  } rpt_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] count;
    logic [31:0] peak;
    logic [15:0] phase;
  } entry_t;

  typedef struct packed {
    logic take_item;
    logic scan_en;
    logic hit_update;
    logic miss_update;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic emit;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/bufrpt_if.sv
// ----------------------------------------------------------------------------
// Buffer report tracker channels
// Valid/ready channels for events, reports and register writes.
// ----------------------------------------------------------------------------
interface bufrpt_req_if;
  import bufrpt_pkg::*;

  logic      valid;
  logic      ready;
  bsr_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bufrpt_rsp_if;
  import bufrpt_pkg::*;

  logic      valid;
  logic      ready;
  rpt_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bufrpt_cfg_if;
  import bufrpt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/bufrpt_ctrl.sv
// ----------------------------------------------------------------------------
// Buffer report tracker controller
// Sequences acceptance, the table scan, the entry update and the report.
// ----------------------------------------------------------------------------
`include "per_ue_buffer_report_tracker_defines.svh"

module bufrpt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bufrpt_pkg::dp_status_t status_i,
  output bufrpt_pkg::ctrl_cmd_t  cmd_o
);
  import bufrpt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_HIT  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.hit) begin
          state_d = S_HIT;
        end else if (status_i.miss) begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        cmd_o.hit_update = 1'b1;
        state_d          = S_OUT;
      end
      S_MISS: begin
        cmd_o.miss_update = 1'b1;
        state_d           = S_OUT;
      end
      S_OUT: begin
        if (!status_i.emit) begin
          state_d = S_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BUFRPT_ASSERT_NEXT(a_accept_starts_scan, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_SCAN, "Accepted event did not start a scan.")
  `BUFRPT_ASSERT_SAME(a_load_when_free, clk_i, rst_ni, cmd_o.load_out, status_i.emit && !status_i.out_busy, "Report loaded into an occupied output register.")
  `BUFRPT_ASSERT_NEVER(a_hit_miss_exclusive, clk_i, rst_ni, status_i.hit && status_i.miss, "Scan reported a hit and a miss together.")

endmodule

>>> rtl/bufrpt_dp.sv
// ----------------------------------------------------------------------------
// Buffer report tracker datapath
// Holds the registers, the user table memory, the scan pointer, the entry
// update arithmetic and the output register.
// ----------------------------------------------------------------------------
`include "per_ue_buffer_report_tracker_defines.svh"

module bufrpt_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bufrpt_pkg::ctrl_cmd_t             cmd_i,
  output bufrpt_pkg::dp_status_t            status_o,
  input  logic                              cfg_valid_i,
  input  logic [bufrpt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bufrpt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  bufrpt_pkg::bsr_item_t             item_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output bufrpt_pkg::rpt_item_t             out_item_o
);
  import bufrpt_pkg::*;

  logic [15:0]       period_q;
  logic [31:0]       thresh_q;
  bsr_item_t         item_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] rd_idx_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;
  entry_t            rdata_q;
  entry_t            mem_q [TABLE_ENTRIES];
  logic [31:0]       res_count_q;
  logic [31:0]       res_peak_q;
  logic              emit_q;
  logic              out_valid_q;
  rpt_item_t         out_q;

  logic              rd_en;
  logic              hit;
  logic              miss;
  logic              full;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [31:0]       cnt_nxt;
  logic [31:0]       peak_nxt;
  logic [16:0]       ph_inc;
  logic [15:0]       ph_nxt;
  logic [15:0]       ph_first;
  logic              burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= REPORT_PERIOD_RST;
      thresh_q <= BURST_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REPORT_PERIOD:   period_q <= cfg_data_i[15:0];
        CFG_BURST_THRESHOLD: thresh_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_q <= item_i;
    end
  end

  assign full  = (fill_q == FILL_W'(TABLE_ENTRIES));
  assign hit   = cmd_i.scan_en && cmp_vld_q && (rdata_q.key == item_q.user_id);
  assign miss  = cmd_i.scan_en && !cmp_vld_q && (rd_idx_q == fill_q);
  assign rd_en = cmd_i.scan_en && !hit && (rd_idx_q != fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.take_item) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        rd_idx_q  <= rd_idx_q + FILL_W'(1);
        cmp_idx_q <= rd_idx_q[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.miss_update && !full) begin
      fill_q <= fill_q + FILL_W'(1);
    end
  end

  always_comb begin
    cnt_nxt  = rdata_q.count + 32'd1;
    peak_nxt = (item_q.buffered_bytes > rdata_q.peak) ? item_q.buffered_bytes : rdata_q.peak;
    ph_inc   = {1'b0, rdata_q.phase} + 17'd1;
    ph_nxt   = (ph_inc >= {1'b0, period_q}) ? 16'd0 : ph_inc[15:0];
    ph_first = (period_q <= 16'd1) ? 16'd0 : 16'd1;
    burst    = (item_q.buffered_bytes >= thresh_q);
  end

  always_comb begin
    wr_en         = cmd_i.hit_update || (cmd_i.miss_update && !full);
    wr_addr       = cmd_i.hit_update ? cmp_idx_q : fill_q[IDX_W-1:0];
    wr_data.key   = item_q.user_id;
    wr_data.count = cmd_i.hit_update ? cnt_nxt : 32'd1;
    wr_data.peak  = cmd_i.hit_update ? peak_nxt : item_q.buffered_bytes;
    wr_data.phase = cmd_i.hit_update ? ph_nxt : ph_first;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_update) begin
      res_count_q <= cnt_nxt;
      res_peak_q  <= peak_nxt;
    end else if (cmd_i.miss_update) begin
      res_count_q <= 32'd1;
      res_peak_q  <= item_q.buffered_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (cmd_i.hit_update) begin
      emit_q <= (ph_nxt == 16'd0) || burst;
    end else if (cmd_i.miss_update) begin
      emit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_time    <= item_q.event_time;
      out_q.out_user    <= item_q.user_id;
      out_q.out_frame   <= item_q.frame_number;
      out_q.out_slot    <= item_q.slot_number;
      out_q.out_kind    <= item_q.report_kind;
      out_q.out_bytes   <= item_q.buffered_bytes;
      out_q.out_group   <= item_q.group_id;
      out_q.event_count <= res_count_q;
      out_q.peak_seen   <= res_peak_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;
  assign status_o.hit      = hit;
  assign status_o.miss     = miss;
  assign status_o.emit     = emit_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  `BUFRPT_ASSERT_NEVER(a_fill_bounded, clk_i, rst_ni, fill_q > FILL_W'(TABLE_ENTRIES), "Table fill count beyond table size.")
  `BUFRPT_ASSERT_NEXT(a_alloc_grows_fill, clk_i, rst_ni, cmd_i.miss_update && !full, fill_q == $past(fill_q) + FILL_W'(1), "Allocation did not advance the fill count.")
  `BUFRPT_ASSERT_SAME(a_hit_in_filled, clk_i, rst_ni, hit, FILL_W'(cmp_idx_q) < fill_q, "Hit on an entry beyond the filled region.")
  `BUFRPT_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, cmd_i.load_out, out_valid_q, "Loaded report not presented.")

endmodule

>>> rtl/per_ue_buffer_report_tracker.sv
// ----------------------------------------------------------------------------
// Per-user buffer status report tracker
// Each accepted event is held while the scan reads the filled table entries
// one per cycle from the memory port until a hit or a miss; the entry is then
// updated or allocated, and the report, if any, is loaded into the output
// register. A report waits while an earlier report has not yet been taken.
// A new event is accepted only after the previous one has been handled.
// Reset clears the table fill count, the registers to 50 and 100000, and the
// controller; the table memory itself is not cleared.
// ----------------------------------------------------------------------------
module per_ue_buffer_report_tracker (
  input logic          clk_i,
  input logic          rst_ni,
  bufrpt_req_if.sink   bsr_in_ch,
  bufrpt_rsp_if.source rpt_out_ch,
  bufrpt_cfg_if.sink   cfg_ch
);
  import bufrpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  bufrpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bsr_in_ch.valid),
    .in_ready_o (bsr_in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bufrpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_index_i (cfg_ch.index),
    .cfg_data_i  (cfg_ch.data),
    .item_i      (bsr_in_ch.payload),
    .out_ready_i (rpt_out_ch.ready),
    .out_valid_o (rpt_out_ch.valid),
    .out_item_o  (rpt_out_ch.payload)
  );

endmodule

>>> tb/sv/tb_per_ue_buffer_report_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the per-user buffer status report tracker
// Drives report events and register writes through valid/ready channels,
// keeps its own copy of the user table to work out every report, and checks
// each report transfer field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_per_ue_buffer_report_tracker;
  import bufrpt_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned QUIET_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned POOL_USERS    = 40;
  localparam int unsigned RANDOM_ROUNDS = 10;
  localparam int unsigned ROUND_EVENTS  = 140;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_IDX = 4'd9;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bufrpt_req_if bsr_if ();
  bufrpt_rsp_if rpt_if ();
  bufrpt_cfg_if cfg_if ();

  per_ue_buffer_report_tracker u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bsr_in_ch (bsr_if),
    .rpt_out_ch(rpt_if),
    .cfg_ch    (cfg_if)
  );

  // Shadow of the user table and of the registers.
  bit          tbl_used  [TABLE_ENTRIES];
  logic [15:0] tbl_user  [TABLE_ENTRIES];
  logic [31:0] tbl_count [TABLE_ENTRIES];
  logic [31:0] tbl_peak  [TABLE_ENTRIES];
  logic [15:0] tbl_phase [TABLE_ENTRIES];
  logic [15:0] period_q = REPORT_PERIOD_RST;
  logic [31:0] burst_q  = BURST_THRESHOLD_RST;

  rpt_item_t   rpt_expected [$];
  logic [15:0] user_pool [POOL_USERS];

  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;
  int unsigned req_gap_max   = 0;
  int unsigned rsp_stall_max = 0;
  int unsigned rsp_wait      = 0;
  logic        rsp_hold      = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] advance_phase(input logic [15:0] phase);
    if ({1'b0, phase} + 17'd1 >= {1'b0, period_q}) begin
      return 16'd0;
    end
    return phase + 16'd1;
  endfunction

  function automatic void track_bsr(input bsr_item_t ev);
    int        hit;
    int        free_idx;
    logic [31:0] count;
    logic [31:0] peak;
    bit        emit;
    rpt_item_t rpt;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_used[i]) begin
        if (hit < 0 && tbl_user[i] == ev.user_id) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      count = tbl_count[hit] + 32'd1;
      tbl_count[hit] = count;
      if (ev.buffered_bytes > tbl_peak[hit]) tbl_peak[hit] = ev.buffered_bytes;
      peak = tbl_peak[hit];
      tbl_phase[hit] = advance_phase(tbl_phase[hit]);
      emit = (tbl_phase[hit] == 16'd0) || (ev.buffered_bytes >= burst_q);
    end else begin
      count = 32'd1;
      peak  = ev.buffered_bytes;
      emit  = 1'b1;
      if (free_idx >= 0) begin
        tbl_used[free_idx]  = 1'b1;
        tbl_user[free_idx]  = ev.user_id;
        tbl_count[free_idx] = 32'd1;
        tbl_peak[free_idx]  = ev.buffered_bytes;
        tbl_phase[free_idx] = advance_phase(16'd0);
      end
    end
    if (emit) begin
      rpt.out_time    = ev.event_time;
      rpt.out_user    = ev.user_id;
      rpt.out_frame   = ev.frame_number;
      rpt.out_slot    = ev.slot_number;
      rpt.out_kind    = ev.report_kind;
      rpt.out_bytes   = ev.buffered_bytes;
      rpt.out_group   = ev.group_id;
      rpt.event_count = count;
      rpt.peak_seen   = peak;
      rpt_expected.push_back(rpt);
    end
  endfunction

  function automatic void flag_field(input string field, input logic [63:0] want,
                                     input logic [63:0] seen);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("report %s mismatch: expected %0h, got %0h", field, want, seen);
    end
  endfunction

  function automatic void check_report(input rpt_item_t got);
    rpt_item_t want;
    if (rpt_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("unexpected report: user %0h, count %0d", got.out_user, got.event_count);
      end
      return;
    end
    want = rpt_expected.pop_front();
    if (got.out_time !== want.out_time) flag_field("out_time", want.out_time, got.out_time);
    if (got.out_user !== want.out_user) begin
      flag_field("out_user", 64'(want.out_user), 64'(got.out_user));
    end
    if (got.out_frame !== want.out_frame) begin
      flag_field("out_frame", 64'(want.out_frame), 64'(got.out_frame));
    end
    if (got.out_slot !== want.out_slot) begin
      flag_field("out_slot", 64'(want.out_slot), 64'(got.out_slot));
    end
    if (got.out_kind !== want.out_kind) begin
      flag_field("out_kind", 64'(want.out_kind), 64'(got.out_kind));
    end
    if (got.out_bytes !== want.out_bytes) begin
      flag_field("out_bytes", 64'(want.out_bytes), 64'(got.out_bytes));
    end
    if (got.out_group !== want.out_group) begin
      flag_field("out_group", 64'(want.out_group), 64'(got.out_group));
    end
    if (got.event_count !== want.event_count) begin
      flag_field("event_count", 64'(want.event_count), 64'(got.event_count));
    end
    if (got.peak_seen !== want.peak_seen) begin
      flag_field("peak_seen", 64'(want.peak_seen), 64'(got.peak_seen));
    end
  endfunction

  // Report side: checks every transfer and draws the idle time after it.
  always @(posedge clk_i) begin
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      check_report(rpt_if.payload);
      rsp_wait = $urandom_range(rsp_stall_max, 0);
    end
    if (rsp_hold || rsp_wait != 0) begin
      rpt_if.ready <= 1'b0;
      if (rsp_wait != 0) rsp_wait--;
    end else begin
      rpt_if.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic bsr_item_t make_bsr(input logic [15:0] user);
    bsr_item_t ev;
    ev.user_id      = user;
    ev.event_time   = {$urandom, $urandom};
    ev.frame_number = 10'($urandom_range(1023, 0));
    ev.slot_number  = 8'($urandom_range(255, 0));
    ev.report_kind  = 1'($urandom_range(1, 0));
    case ($urandom_range(7, 0))
      0:       ev.buffered_bytes = 32'd0;
      1:       ev.buffered_bytes = 32'hFFFF_FFFF;
      2:       ev.buffered_bytes = burst_q;
      3:       ev.buffered_bytes = burst_q - 32'd1;
      4:       ev.buffered_bytes = burst_q + 32'd1;
      5:       ev.buffered_bytes = $urandom_range(200000, 0);
      default: ev.buffered_bytes = $urandom;
    endcase
    if ($urandom_range(3, 0) == 0) begin
      ev.group_id = 8'($urandom_range(255, 0));
    end else if ($urandom_range(8, 0) == 8) begin
      ev.group_id = 8'd255;
    end else begin
      ev.group_id = 8'($urandom_range(7, 0));
    end
    return ev;
  endfunction

  task automatic send_bsr(input bsr_item_t ev);
    int unsigned gap;
    gap = $urandom_range(req_gap_max, 0);
    if (gap != 0) begin
      bsr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    bsr_if.valid   <= 1'b1;
    bsr_if.payload <= ev;
    do @(posedge clk_i); while (!bsr_if.ready);
    track_bsr(ev);
  endtask

  task automatic send_bytes(input logic [15:0] user, input logic [31:0] bytes);
    bsr_item_t ev;
    ev = make_bsr(user);
    ev.buffered_bytes = bytes;
    send_bsr(ev);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_REPORT_PERIOD:   period_q = data[15:0];
      CFG_BURST_THRESHOLD: burst_q  = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every report has arrived, then lets any silent events finish.
  task automatic settle();
    int unsigned waited;
    bsr_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (rpt_expected.size() != 0 && waited < DRAIN_LIMIT);
    if (rpt_expected.size() != 0) begin
      $display("%0d report(s) never arrived", rpt_expected.size());
      mismatches += rpt_expected.size();
      rpt_expected.delete();
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_first_reports();
    req_gap_max   = 0;
    rsp_stall_max = 0;
    send_bsr('{16'h0000, 64'h0, 10'h000, 8'h00, 1'b0, 32'h0, 8'h00});
    send_bsr('{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 8'hFF});
    send_bytes(16'h0000, 32'd99999);
    send_bytes(16'h0000, 32'd100000);
    send_bytes(16'h0000, 32'd5);
    send_bytes(16'hFFFF, 32'd0);
    send_bsr('{16'h1234, 64'h8000_0000_0000_0001, 10'h155, 8'hAA, 1'b0, 32'd7, 8'd7});
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(CFG_REPORT_PERIOD, 32'd1);
    write_reg(CFG_BURST_THRESHOLD, 32'hFFFF_FFFF);
    send_bytes(16'h0000, 32'd0);
    send_bytes(16'h1234, 32'd3);
    settle();
    write_reg(CFG_UNMAPPED_IDX, 32'd0);
    send_bytes(16'h0000, 32'd1);
    settle();
    // Only the low half reaches the period, which leaves it at zero.
    write_reg(CFG_REPORT_PERIOD, 32'hABCD_0000);
    send_bytes(16'hFFFF, 32'd2);
    settle();
    write_reg(CFG_REPORT_PERIOD, 32'h0000_FFFF);
    write_reg(CFG_BURST_THRESHOLD, 32'd0);
    send_bytes(16'h0000, 32'd0);
    settle();
    write_reg(CFG_BURST_THRESHOLD, 32'hFFFF_FFFF);
    send_bytes(16'h1234, 32'hFFFF_FFFE);
    send_bytes(16'h1234, 32'hFFFF_FFFF);
    settle();
    // A phase left beyond a shortened period wraps on the next event.
    write_reg(CFG_REPORT_PERIOD, 32'd5);
    send_bytes(16'h0042, 32'd10);
    send_bytes(16'h0042, 32'd10);
    send_bytes(16'h0042, 32'd10);
    settle();
    write_reg(CFG_REPORT_PERIOD, 32'd2);
    send_bytes(16'h0042, 32'd10);
  endtask

  task automatic test_random_traffic();
    logic [15:0] user;
    for (int i = 0; i < POOL_USERS; i++) user_pool[i] = 16'($urandom_range(65535, 0));
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      settle();
      case ($urandom_range(5, 0))
        0:       write_reg(CFG_REPORT_PERIOD, 32'd1);
        1:       write_reg(CFG_REPORT_PERIOD, 32'd2);
        2:       write_reg(CFG_REPORT_PERIOD, {16'($urandom_range(65535, 0)), 16'd65535});
        3:       write_reg(CFG_REPORT_PERIOD, 32'd50);
        default: write_reg(CFG_REPORT_PERIOD, $urandom_range(8, 3));
      endcase
      case ($urandom_range(3, 0))
        0: write_reg(CFG_BURST_THRESHOLD, $urandom);
        1: write_reg(CFG_BURST_THRESHOLD, 32'hFFFF_FFFF);
        2: write_reg(CFG_BURST_THRESHOLD, 32'd1 << $urandom_range(31, 0));
        3: write_reg(CFG_BURST_THRESHOLD, 32'd100000);
      endcase
      case (round % 4)
        0: begin
          req_gap_max   = 0;
          rsp_stall_max = 0;
        end
        1: begin
          req_gap_max   = 15;
          rsp_stall_max = 15;
        end
        2: begin
          req_gap_max   = 15;
          rsp_stall_max = 0;
        end
        default: begin
          req_gap_max   = 3;
          rsp_stall_max = 15;
        end
      endcase
      repeat (ROUND_EVENTS) begin
        // The first round allocates the regular users before the table fills.
        if (round != 0 && $urandom_range(99, 0) < 15) begin
          user = 16'($urandom_range(65535, 0));
        end else begin
          user = user_pool[$urandom_range(POOL_USERS - 1, 0)];
        end
        send_bsr(make_bsr(user));
      end
    end
  endtask

  task automatic test_report_backpressure();
    settle();
    write_reg(CFG_REPORT_PERIOD, 32'd1);
    write_reg(CFG_BURST_THRESHOLD, 32'd0);
    req_gap_max   = 0;
    rsp_stall_max = 0;
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rsp_hold <= 1'b0;
      end
    join_none
    repeat (40) send_bsr(make_bsr(user_pool[$urandom_range(POOL_USERS - 1, 0)]));
  endtask

  task automatic test_sender_pause();
    settle();
    write_reg(CFG_REPORT_PERIOD, 32'd2);
    write_reg(CFG_BURST_THRESHOLD, $urandom);
    req_gap_max   = 7;
    rsp_stall_max = 15;
    repeat (30) send_bsr(make_bsr(user_pool[$urandom_range(POOL_USERS - 1, 0)]));
    bsr_if.valid <= 1'b0;
    do @(posedge clk_i); while (rpt_expected.size() != 0);
    repeat (30) send_bsr(make_bsr(user_pool[$urandom_range(POOL_USERS - 1, 0)]));
  endtask

  initial begin
    bsr_if.valid   <= 1'b0;
    bsr_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_reports();
    test_register_extremes();
    test_random_traffic();
    test_report_backpressure();
    test_sender_pause();
    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
